### rtl/vps_pkg.sv
// shared constants for the pixel statistic accumulator
`timescale 1ns / 1ps
`default_nettype none
package vps_pkg;

  localparam int unsigned PIX_W      = 32;
  localparam int unsigned GAIN_W     = 23;
  localparam int unsigned WIDE_W     = 64;
  localparam int unsigned PROD_W     = 2 * PIX_W;
  localparam int unsigned IN_DATA_W  = 160;
  localparam int unsigned OUT_DATA_W = 256;

  localparam logic [GAIN_W-1:0] GAIN_LIMIT_RESET = 23'd6553600;
  localparam logic [PIX_W-1:0]  NOISE_VAR        = 32'd131072;
  localparam logic [PIX_W-1:0]  ROUND_HALF       = 32'h8000_0000;

  // log2 is built from this many squaring steps
  localparam int unsigned LOG_ITERS  = 40;
  localparam int unsigned LOG_IT_W   = 6;
  localparam int unsigned DIV_STEPS  = 64;
  localparam int unsigned DIV_CNT_W  = 6;

endpackage
`default_nettype wire

### rtl/vps_mul.sv
// shared 32 x 32 unsigned multiplier with registered product
`timescale 1ns / 1ps
`default_nettype none
module vps_mul (
  input  wire logic                          clk,
  input  wire logic [vps_pkg::PIX_W-1:0]     a,
  input  wire logic [vps_pkg::PIX_W-1:0]     b,
  output logic      [vps_pkg::PROD_W-1:0]    prod
);

  // one partial product per cycle
  always_ff @(posedge clk) begin
    prod <= vps_pkg::PROD_W'(a) * vps_pkg::PROD_W'(b);
  end

endmodule
`default_nettype wire

### rtl/vps_div.sv
// serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module vps_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [vps_pkg::WIDE_W-1:0]    dividend,
  input  wire logic [vps_pkg::PIX_W-1:0]     divisor,
  output logic                               done,
  output logic      [vps_pkg::WIDE_W-1:0]    quotient
);

  logic                            busy;
  logic [vps_pkg::DIV_CNT_W-1:0]   cnt;
  logic [vps_pkg::PIX_W:0]         rem;
  logic [vps_pkg::WIDE_W-1:0]      dvd;
  logic [vps_pkg::PIX_W:0]         trial;
  logic                            fits;

  // trial subtract of the next dividend bit
  assign trial = {rem[vps_pkg::PIX_W-1:0], dvd[vps_pkg::WIDE_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        dvd      <= dividend;
        quotient <= '0;
      end else if (busy) begin
        rem      <= fits ? (trial - {1'b0, divisor}) : trial;
        quotient <= {quotient[vps_pkg::WIDE_W-2:0], fits};
        dvd      <= {dvd[vps_pkg::WIDE_W-2:0], 1'b0};
        cnt      <= cnt + 1'b1;
        if (cnt == vps_pkg::DIV_CNT_W'(vps_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

### rtl/vif_pixel_statistic_accumulator.sv
// Per-pixel statistic accumulator: one pixel per input beat (five 32-bit moments, tlast marks
// the end of the plane). Variances and mean products run on one shared 32x32 multiplier, four
// partial products per wide multiply. A log-path pixel adds a serial division, up to three
// normalizations of one bit per cycle, and up to three log2 evaluations of 40 squarings each;
// the log squarings on the shared multiplier dominate the time a pixel takes.
// The block takes no pixel while one is in work. On the tlast pixel the seven sums go out as
// one master beat and are cleared; a finished beat waits in the output register.
`timescale 1ns / 1ps
`default_nettype none
module vif_pixel_statistic_accumulator (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // gain limit register, unsigned Q7.16
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [vps_pkg::GAIN_W-1:0]         cfg_data,
  // pixel beats
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // ref_mean, dis_mean, ref_sq_mean, dis_sq_mean, cross_mean (32 bits each)
  input  wire logic [vps_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  input  wire logic                               s_axis_tlast,
  // result beats
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // num_log_sum 48, den_log_sum 47, num_linear_sum 54, linear_count 23,
  // den_shift_sum 27, num_shift_sum 29, log_count 23, zero pad 5
  output logic      [vps_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

  typedef enum logic [4:0] {
    S_IDLE, S_M_ISSUE, S_M_ADD, S_P11, S_P22, S_P12, S_SIGMA, S_BRANCH,
    S_NORM, S_DEN_LOG, S_LOG, S_LOG_STEP, S_DEN_ADD, S_DIV_WAIT, S_SV,
    S_GSQ, S_T, S_N1_LOG, S_N1_DONE, S_N2_LOG, S_N2_DONE, S_DONE
  } state_t;

  state_t state, ret, nret, log_ret;

  logic [vps_pkg::GAIN_W-1:0]   gain_limit;
  logic [31:0]  mu1, mu2, xx, yy, xy;
  logic         last;
  logic [31:0]  p11, p22, p12;
  logic [31:0]  s1, s2, d12;
  logic [63:0]  ma, mb;
  logic [1:0]   k;
  logic [127:0] acc;
  logic [63:0]  lx;
  logic [39:0]  frac;
  logic [vps_pkg::LOG_IT_W-1:0] it;
  logic [63:0]  nv;
  logic [5:0]   nsh, sh1;
  logic [15:0]  l1;
  logic [63:0]  gq;
  logic [31:0]  sv;

  logic [47:0]  num_log_acc, den_log_acc;
  logic [53:0]  num_linear_acc;
  logic [22:0]  linear_cnt, log_cnt;
  logic [27:0]  den_shift_acc;
  logic [29:0]  num_shift_acc;

  // shared units
  logic [31:0]  mul_a, mul_b;
  logic [63:0]  prod;
  logic         div_start, div_done;
  logic [63:0]  div_q;

  vps_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

  vps_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend({d12, 32'd0}), .divisor(s1),
    .done(div_done), .quotient(div_q)
  );

  assign mul_a     = k[0] ? ma[63:32] : ma[31:0];
  assign mul_b     = k[1] ? mb[63:32] : mb[31:0];
  assign div_start = (state == S_DEN_ADD) && !d12[31];

  // partial product placed at its weight
  logic [127:0] pp;
  always_comb begin
    case (k)
      2'd0:         pp = {64'd0, prod};
      2'd1, 2'd2:   pp = {32'd0, prod, 32'd0};
      default:      pp = {prod, 64'd0};
    endcase
  end

  // rounded mean product out of the low word
  logic [63:0] rnd;
  assign rnd = acc[63:0] + {32'd0, vps_pkg::ROUND_HALF};

  // variances from the latched moments
  logic [31:0] d1w, d2w, d12w;
  assign d1w  = xx - p11;
  assign d2w  = yy - p22;
  assign d12w = xy - p12;

  // log2 * 2048 rounded from the collected fraction bits
  logic [44:0] l_rnd;
  logic [15:0] logv;
  assign l_rnd = {5'd15, 40'd0} + {5'd0, frac} + 45'(1 << 28);
  assign logv  = l_rnd[44:29];

  // residual variance and gain clamp
  logic [63:0] big, sv_diff, lim, numer1, t_sum, g_cl;
  assign big     = {s2, 32'd0};
  assign sv_diff = big - acc[63:0];
  assign lim     = {25'd0, gain_limit, 16'd0};
  assign g_cl    = (gq < lim) ? gq : lim;
  assign numer1  = {32'd0, sv} + {32'd0, vps_pkg::NOISE_VAR};
  assign t_sum   = acc[95:32] + numer1;

  logic [16:0] num_val;
  assign num_val = {1'b0, l1} - {1'b0, logv};

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      gain_limit     <= vps_pkg::GAIN_LIMIT_RESET;
      m_axis_tvalid  <= 1'b0;
      num_log_acc    <= '0;
      den_log_acc    <= '0;
      num_linear_acc <= '0;
      linear_cnt     <= '0;
      den_shift_acc  <= '0;
      num_shift_acc  <= '0;
      log_cnt        <= '0;
      k              <= '0;
    end else begin
      if (cfg_valid) gain_limit <= cfg_data;
      // a taken beat clears unless a new one is loaded in the same cycle
      if (m_axis_tvalid && m_axis_tready && !(state == S_DONE && last))
        m_axis_tvalid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            mu1   <= s_axis_tdata[31:0];
            mu2   <= s_axis_tdata[63:32];
            xx    <= s_axis_tdata[95:64];
            yy    <= s_axis_tdata[127:96];
            xy    <= s_axis_tdata[159:128];
            last  <= s_axis_tlast;
            ma    <= {32'd0, s_axis_tdata[31:0]};
            mb    <= {32'd0, s_axis_tdata[31:0]};
            acc   <= '0;
            k     <= '0;
            ret   <= S_P11;
            state <= S_M_ISSUE;
          end
        end
        // wide multiply over four partial products
        S_M_ISSUE: state <= S_M_ADD;
        S_M_ADD: begin
          acc <= acc + pp;
          k   <= k + 1'b1;
          state <= (k == 2'd3) ? ret : S_M_ISSUE;
        end
        S_P11: begin
          p11 <= rnd[63:32];
          ma <= {32'd0, mu2}; mb <= {32'd0, mu2}; acc <= '0;
          ret <= S_P22; state <= S_M_ISSUE;
        end
        S_P22: begin
          p22 <= rnd[63:32];
          ma <= {32'd0, mu1}; mb <= {32'd0, mu2}; acc <= '0;
          ret <= S_P12; state <= S_M_ISSUE;
        end
        S_P12: begin
          p12   <= rnd[63:32];
          state <= S_SIGMA;
        end
        S_SIGMA: begin
          s1    <= d1w[31] ? 32'd0 : d1w;
          s2    <= d2w[31] ? 32'd0 : d2w;
          d12   <= d12w;
          state <= S_BRANCH;
        end
        S_BRANCH: begin
          if (s1 < vps_pkg::NOISE_VAR) begin
            num_linear_acc <= num_linear_acc + {22'd0, s2};
            linear_cnt     <= linear_cnt + 1'b1;
            state          <= S_DONE;
          end else begin
            log_cnt <= log_cnt + 1'b1;
            nv      <= {32'd0, s1} + {32'd0, vps_pkg::NOISE_VAR};
            nsh     <= '0;
            nret    <= S_DEN_LOG;
            state   <= S_NORM;
          end
        end
        // one right shift per cycle until 16 bits remain
        S_NORM: begin
          if (nv[63:16] != '0) begin
            nv  <= {1'b0, nv[63:1]};
            nsh <= nsh + 1'b1;
          end else begin
            state <= nret;
          end
        end
        S_DEN_LOG: begin
          den_shift_acc <= den_shift_acc - {22'd0, nsh};
          lx <= {nv[15:0], 48'd0}; frac <= '0; it <= '0;
          log_ret <= S_DEN_ADD; state <= S_LOG;
        end
        // log2 by repeated squaring, one fraction bit per square
        S_LOG: begin
          ma <= lx; mb <= lx; acc <= '0;
          ret <= S_LOG_STEP; state <= S_M_ISSUE;
        end
        S_LOG_STEP: begin
          frac <= {frac[38:0], acc[127]};
          lx   <= acc[127] ? acc[127:64] : acc[126:63];
          it   <= it + 1'b1;
          state <= (it == vps_pkg::LOG_IT_W'(vps_pkg::LOG_ITERS - 1)) ? log_ret : S_LOG;
        end
        S_DEN_ADD: begin
          den_log_acc <= den_log_acc + {32'd0, logv};
          state <= d12[31] ? S_DONE : S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            gq  <= div_q;
            acc <= '0;
            if (s2 == '0) begin
              sv <= '0;
              ma <= '0; mb <= '0;
              ret <= S_GSQ;
            end else begin
              ma <= div_q; mb <= {32'd0, d12};
              ret <= S_SV;
            end
            state <= S_M_ISSUE;
          end
        end
        S_SV: begin
          sv <= ((acc[127:64] != '0) || (acc[63:0] >= big)) ? 32'd0 : sv_diff[63:32];
          ma <= g_cl; mb <= g_cl; acc <= '0;
          ret <= S_GSQ; state <= S_M_ISSUE;
        end
        S_GSQ: begin
          ma <= acc[95:32]; mb <= {32'd0, s1}; acc <= '0;
          ret <= S_T; state <= S_M_ISSUE;
        end
        S_T: begin
          nv <= t_sum; nsh <= '0;
          nret <= S_N1_LOG; state <= S_NORM;
        end
        S_N1_LOG: begin
          sh1 <= nsh;
          lx <= {nv[15:0], 48'd0}; frac <= '0; it <= '0;
          log_ret <= S_N1_DONE; state <= S_LOG;
        end
        S_N1_DONE: begin
          l1 <= logv;
          nv <= numer1; nsh <= '0;
          nret <= S_N2_LOG; state <= S_NORM;
        end
        S_N2_LOG: begin
          lx <= {nv[15:0], 48'd0}; frac <= '0; it <= '0;
          log_ret <= S_N2_DONE; state <= S_LOG;
        end
        S_N2_DONE: begin
          num_log_acc   <= num_log_acc + {{31{num_val[16]}}, num_val};
          num_shift_acc <= num_shift_acc + {24'd0, sh1} - {24'd0, nsh};
          state <= S_DONE;
        end
        S_DONE: begin
          if (!last) begin
            state <= S_IDLE;
          end else if (!m_axis_tvalid || m_axis_tready) begin
            // emit the plane sums and clear them
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {5'd0, log_cnt, num_shift_acc[28:0], den_shift_acc[26:0],
                              linear_cnt, num_linear_acc, den_log_acc[46:0], num_log_acc};
            num_log_acc    <= '0;
            den_log_acc    <= '0;
            num_linear_acc <= '0;
            linear_cnt     <= '0;
            den_shift_acc  <= '0;
            num_shift_acc  <= '0;
            log_cnt        <= '0;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/vps_chk.sv
// port checker for the pixel statistic accumulator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module vps_chk (
  input wire logic clk,
  input wire logic rst,
  input wire logic cfg_ready,
  input wire logic s_axis_tvalid,
  input wire logic s_axis_tready,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready,
  input wire logic [vps_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  // a pixel in work blocks the next beat
  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("pixel taken while previous one in work");

  // reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> s_axis_tready && !m_axis_tvalid)
    else $error("block not idle after reset");

  // a new result rises only with the block back at idle, ready for the next pixel
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result beat without finishing a pixel");

  // result beat holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // register port never stalls
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("register port stalled");

endmodule

bind vif_pixel_statistic_accumulator vps_chk u_vps_chk (
  .clk(clk), .rst(rst), .cfg_ready(cfg_ready),
  .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
